@@ sv/fcdma_pkg.sv @@
// Shared types and constants for the four-channel DMA controller.
`default_nettype none
package fcdma_pkg;

	localparam int MAX_CH = 8;
	localparam int QDEPTH = 2;
	localparam int SPECIAL_CH = 3;

	localparam logic [2:0] REQ_PROGRAM = 3'd0;
	localparam logic [2:0] REQ_VBLANK = 3'd1;
	localparam logic [2:0] REQ_HBLANK = 3'd2;
	localparam logic [2:0] REQ_SPECIAL = 3'd3;
	localparam logic [2:0] REQ_STEP = 3'd4;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_PROG = 2'd1;
	localparam logic [1:0] CMD_TRIG = 2'd2;
	localparam logic [1:0] CMD_STEP = 2'd3;

	localparam logic [1:0] TIM_IMMEDIATE = 2'd0;
	localparam logic [1:0] TIM_SPECIAL = 2'd3;

	localparam logic [1:0] SMODE_INC = 2'd0;
	localparam logic [1:0] SMODE_DEC = 2'd1;

	localparam logic [1:0] TMODE_INC = 2'd0;
	localparam logic [1:0] TMODE_DEC = 2'd1;
	localparam logic [1:0] TMODE_RELOAD = 2'd3;

	localparam logic [16:0] CNT_FULL = 17'h10000;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [1:0]  channel;
		logic [31:0] source_addr;
		logic [31:0] target_addr;
		logic [16:0] unit_count;
		logic        word_size;
		logic [1:0]  source_mode;
		logic [1:0]  target_mode;
		logic        repeat_on;
		logic [1:0]  timing;
		logic        irq_enable;
		logic        drq_enable;
	} req_t;

	typedef struct packed {
		logic        transfer_valid;
		logic [1:0]  active_channel;
		logic [31:0] read_address;
		logic [31:0] write_address;
		logic        unit_is_word;
		logic        nonsequential;
		logic        run_finished;
		logic        dma_irq;
		logic        cartridge_irq;
	} rsp_t;

	typedef struct packed {
		logic       word_size;
		logic [1:0] source_mode;
		logic [1:0] target_mode;
		logic       repeat_on;
		logic [1:0] timing;
		logic       irq_enable;
		logic       drq_enable;
	} settings_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        channel;
		logic [1:0]        trig_code;
		logic [MAX_CH-1:0] trig_mask;
		logic [31:0]       source;
		logic [31:0]       target;
		logic [16:0]       count;
		settings_t         settings;
	} cmd_t;

endpackage
`default_nettype wire

@@ sv/four_channel_dma_controller.sv @@
// Four-channel DMA controller top level: decoder, command queue and execution side.
// Each request word is queued, then its response word is registered in rsp_q.
// One request per cycle while req_stall is low; the queue absorbs response stalls.
// The response register is loaded when empty or when the current response is taken.
// Reset: every channel disabled and idle, command queue empty, no response held.
`default_nettype none
module four_channel_dma_controller #(
	parameter int NUM_CHANNELS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  fcdma_pkg::req_t  req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output fcdma_pkg::rsp_t  rsp
);

	fcdma_pkg::cmd_t dec_cmd;
	fcdma_pkg::cmd_t head;
	logic            q_full;
	logic            head_valid;
	logic            pop;

	assign req_stall = q_full;

	fcdma_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.req(req),
		.cmd(dec_cmd)
	);

	fcdma_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(req_valid),
		.push_data(dec_cmd),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	fcdma_back #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
`default_nettype wire

@@ sv/fcdma_front.sv @@
// Request decoder: classifies each word into a command for the execution side.
`default_nettype none
module fcdma_front #(
	parameter int NUM_CHANNELS = 4
) (
	input  fcdma_pkg::req_t req,
	output fcdma_pkg::cmd_t cmd
);

	logic        cnt_bad;
	logic        ch_ok;
	logic [16:0] cnt_norm;

	assign cnt_bad = (req.unit_count == 17'd0)
		|| (req.unit_count[16] && (req.unit_count[15:0] != 16'd0));
	assign cnt_norm = cnt_bad ? fcdma_pkg::CNT_FULL : req.unit_count;
	assign ch_ok = (32'(req.channel) < NUM_CHANNELS);

	always_comb begin
		cmd.kind = fcdma_pkg::CMD_NONE;
		case (req.req_type)
			fcdma_pkg::REQ_PROGRAM: begin
				if (ch_ok) cmd.kind = fcdma_pkg::CMD_PROG;
			end
			fcdma_pkg::REQ_VBLANK,
			fcdma_pkg::REQ_HBLANK,
			fcdma_pkg::REQ_SPECIAL: cmd.kind = fcdma_pkg::CMD_TRIG;
			fcdma_pkg::REQ_STEP: cmd.kind = fcdma_pkg::CMD_STEP;
			default: cmd.kind = fcdma_pkg::CMD_NONE;
		endcase
		cmd.channel = req.channel;
		cmd.trig_code = req.req_type[1:0];
		for (int i = 0; i < fcdma_pkg::MAX_CH; i++) begin
			if (req.req_type == fcdma_pkg::REQ_SPECIAL)
				cmd.trig_mask[i] = (i == fcdma_pkg::SPECIAL_CH) && (i < NUM_CHANNELS);
			else
				cmd.trig_mask[i] = 1'b1;
		end
		cmd.source = req.source_addr;
		cmd.target = req.target_addr;
		cmd.count = cnt_norm;
		cmd.settings.word_size = req.word_size;
		cmd.settings.source_mode = req.source_mode;
		cmd.settings.target_mode = req.target_mode;
		cmd.settings.repeat_on = req.repeat_on;
		cmd.settings.timing = req.timing;
		cmd.settings.irq_enable = req.irq_enable;
		cmd.settings.drq_enable = req.drq_enable;
	end

endmodule
`default_nettype wire

@@ sv/fcdma_queue.sv @@
// Short command queue between the decoder and the execution side.
`default_nettype none
module fcdma_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  fcdma_pkg::cmd_t      push_data,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output fcdma_pkg::cmd_t      head
);

	localparam int PTR_W = (fcdma_pkg::QDEPTH > 1) ? $clog2(fcdma_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(fcdma_pkg::QDEPTH + 1);

	fcdma_pkg::cmd_t  slot_q [fcdma_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full = (cnt_q == CNT_W'(fcdma_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(fcdma_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(fcdma_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(fcdma_pkg::QDEPTH))
		else $error("queue count above depth");

	a_cnt_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("queue count not reduced on pop");

endmodule
`default_nettype wire

@@ sv/fcdma_back.sv @@
// Channel state and execution: programming, triggers and transfer steps.
`default_nettype none
module fcdma_back #(
	parameter int NUM_CHANNELS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  fcdma_pkg::cmd_t  head,
	output logic             pop,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output fcdma_pkg::rsp_t  rsp
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [31:0]            src_q  [NUM_CHANNELS];
	logic [31:0]            tgt_q  [NUM_CHANNELS];
	logic [31:0]            rtgt_q [NUM_CHANNELS];
	logic [16:0]            rem_q  [NUM_CHANNELS];
	logic [16:0]            rld_q  [NUM_CHANNELS];
	fcdma_pkg::settings_t   set_q  [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] en_q;
	logic [NUM_CHANNELS-1:0] pend_q;

	fcdma_pkg::rsp_t      rsp_q;
	logic                 rsp_valid_q;

	logic                 found;
	logic [CH_W-1:0]      pick;
	logic [CH_W-1:0]      pch;
	fcdma_pkg::settings_t st;
	logic [31:0]          seek;
	logic [31:0]          src_nx;
	logic [31:0]          tgt_nx;
	logic [16:0]          cnt_nx;
	logic                 fin;
	logic                 step_go;
	fcdma_pkg::rsp_t      rsp_d;

	assign pop = head_valid && (!rsp_valid_q || !rsp_stall);
	assign pch = CH_W'(head.channel);

	always_comb begin
		found = 1'b0;
		pick = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				found = 1'b1;
				pick = CH_W'(i);
			end
		end
	end

	always_comb begin
		st = set_q[pick];
		seek = st.word_size ? 32'd4 : 32'd2;
		case (st.source_mode)
			fcdma_pkg::SMODE_INC: src_nx = src_q[pick] + seek;
			fcdma_pkg::SMODE_DEC: src_nx = src_q[pick] - seek;
			default: src_nx = src_q[pick];
		endcase
		case (st.target_mode)
			fcdma_pkg::TMODE_INC,
			fcdma_pkg::TMODE_RELOAD: tgt_nx = tgt_q[pick] + seek;
			fcdma_pkg::TMODE_DEC: tgt_nx = tgt_q[pick] - seek;
			default: tgt_nx = tgt_q[pick];
		endcase
		cnt_nx = rem_q[pick] - 17'd1;
		fin = (cnt_nx == 17'd0);
		step_go = (head.kind == fcdma_pkg::CMD_STEP) && found;

		rsp_d = '0;
		if (step_go) begin
			rsp_d.transfer_valid = 1'b1;
			rsp_d.active_channel = 2'(pick);
			rsp_d.read_address = src_q[pick];
			rsp_d.write_address = tgt_q[pick];
			rsp_d.unit_is_word = st.word_size;
			rsp_d.nonsequential = (rem_q[pick] == rld_q[pick]);
			rsp_d.run_finished = fin;
			rsp_d.dma_irq = st.irq_enable;
			rsp_d.cartridge_irq = (NUM_CHANNELS > fcdma_pkg::SPECIAL_CH)
				&& (32'(pick) == fcdma_pkg::SPECIAL_CH) && st.drq_enable;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.kind == fcdma_pkg::CMD_PROG) begin
				src_q[pch] <= head.source;
				tgt_q[pch] <= head.target;
				rtgt_q[pch] <= head.target;
				rem_q[pch] <= head.count;
				rld_q[pch] <= head.count;
				set_q[pch] <= head.settings;
			end else if (step_go) begin
				src_q[pick] <= src_nx;
				tgt_q[pick] <= (fin && (st.target_mode == fcdma_pkg::TMODE_RELOAD))
					? rtgt_q[pick] : tgt_nx;
				rem_q[pick] <= (fin && st.repeat_on) ? rld_q[pick] : cnt_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			pend_q <= '0;
		end else if (pop) begin
			case (head.kind)
				fcdma_pkg::CMD_PROG: begin
					en_q[pch] <= 1'b1;
					pend_q[pch] <= (head.settings.timing == fcdma_pkg::TIM_IMMEDIATE);
				end
				fcdma_pkg::CMD_TRIG: begin
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						if (en_q[i] && head.trig_mask[i] && (set_q[i].timing == head.trig_code))
							pend_q[i] <= 1'b1;
					end
				end
				fcdma_pkg::CMD_STEP: begin
					if (found && fin) begin
						pend_q[pick] <= 1'b0;
						if (!st.repeat_on) en_q[pick] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (pop) rsp_valid_q <= 1'b1;
		else if (!rsp_stall) rsp_valid_q <= 1'b0;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_pend_en: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~en_q) == '0)
		else $error("channel pending while disabled");

	a_fin_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.run_finished) |-> rsp_q.transfer_valid)
		else $error("run finished without a transfer");

	a_step_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && step_go && fin) |=> !pend_q[$past(pick)])
		else $error("finished channel still pending");

endmodule
`default_nettype wire
